@@ sv/tlf_pkg.sv @@
`timescale 1ns / 1ps

package tlf_pkg;

	localparam int BUF_SIZE = 128;
	localparam int IDX_W    = $clog2(BUF_SIZE);
	localparam int BANK_DEPTH = BUF_SIZE / 2;
	localparam int BANK_AW  = $clog2(BANK_DEPTH);

	localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(BUF_SIZE - 1);

	localparam logic [1:0] ACT_BYTE    = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [7:0] CH_AT  = 8'h40;
	localparam logic [7:0] CH_N   = 8'h6E;
	localparam logic [7:0] CH_R   = 8'h72;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BSL = 8'h5C;

	typedef struct packed {
		logic             frame_ready;
		logic [IDX_W-1:0] frame_length;
		logic             hit;
		logic             bank;
		logic             byte_dropped;
	} stage_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

endpackage

@@ sv/tlf_if.sv @@
`timescale 1ns / 1ps

interface tlf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] rx_byte;
	logic [6:0] read_index;

	modport source (output valid, action, rx_byte, read_index, input ready);
	modport sink (input valid, action, rx_byte, read_index, output ready);
endinterface

interface tlf_out_if;
	logic       valid;
	logic       ready;
	logic       frame_ready;
	logic [6:0] frame_length;
	logic [7:0] read_char;
	logic       byte_dropped;

	modport source (output valid, frame_ready, frame_length, read_char, byte_dropped,
		input ready);
	modport sink (input valid, frame_ready, frame_length, read_char, byte_dropped,
		output ready);
endinterface

@@ sv/tlf_ram.sv @@
`timescale 1ns / 1ps

module tlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/text_line_framer.sv @@
`timescale 1ns / 1ps

// text line framer
// item channel: one beat per action. action 0 feeds a received byte into the
// current frame, action 1 reads the stored byte at read_index, action 2
// releases a held frame. result channel: one beat per item, giving the held
// flag and fill count after the update, the read byte (0 for other actions
// or at/past the frame length) and whether a received byte was dropped.
// the frame store is two 64 x 8 banks (even and odd positions) with a
// registered read, so an escaped byte can store a backslash and the byte in
// the same cycle. control state sits in flops and updates on acceptance.
// the store read and the control update happen at the accepting edge into
// the stage register, and the output register loads from that stage when
// it advances, which can wait while the result side stalls.
// throughput: one item per cycle when the result side keeps ready high.
// when the result side stalls, the output register and one in-flight stage
// fill, then item ready drops until the output register is taken.
// reset clears the control state and both pipeline valids; the store
// content is left as is and is only returned below the fill count.
module text_line_framer (
	input  logic      clk,
	input  logic      arst_n,
	tlf_in_if.sink    item,
	tlf_out_if.source result
);

	localparam int IW = tlf_pkg::IDX_W;

	logic          recv_q, esc_q, held_q;
	logic [IW-1:0] fill_q;

	logic          n_recv, n_esc, n_held;
	logic [IW-1:0] n_fill, fc1, fc2;
	logic          cont, dropped;
	tlf_pkg::wr_t  wa, wb;

	logic             accept, advance;
	logic             valid_s1;
	tlf_pkg::stage_t  st_s1, st_next;
	logic             out_valid_q;
	tlf_pkg::stage_t  out_q;
	logic [7:0]       out_char_q;
	logic [7:0]       rdata [2];

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	always_comb begin
		n_recv  = recv_q;
		n_esc   = esc_q;
		n_held  = held_q;
		n_fill  = fill_q;
		fc1     = fill_q;
		fc2     = fill_q;
		cont    = 1'b1;
		dropped = 1'b0;
		wa      = '{en: 1'b0, addr: fill_q, data: tlf_pkg::CH_BSL};
		wb      = '{en: 1'b0, addr: fill_q, data: item.rx_byte};
		case (item.action)
			tlf_pkg::ACT_BYTE: begin
				if (held_q) begin
					dropped = 1'b1;
				end else if (!recv_q) begin
					n_recv = 1'b1;
					n_fill = '0;
					if (item.rx_byte != tlf_pkg::CH_AT) begin
						wb.en   = 1'b1;
						wb.addr = '0;
						n_fill  = IW'(1);
					end
				end else begin
					if (esc_q) begin
						n_esc = 1'b0;
						if (item.rx_byte == tlf_pkg::CH_N || item.rx_byte == tlf_pkg::CH_R) begin
							n_recv = 1'b0;
							n_held = 1'b1;
							cont   = 1'b0;
						end else if (fill_q < tlf_pkg::FILL_MAX) begin
							wa.en = 1'b1;
							fc1   = fill_q + IW'(1);
						end
					end
					fc2 = fc1;
					if (cont) begin
						if (item.rx_byte == tlf_pkg::CH_BSL) begin
							n_esc = 1'b1;
						end else if (item.rx_byte == tlf_pkg::CH_LF ||
							item.rx_byte == tlf_pkg::CH_CR) begin
							n_recv = 1'b0;
							n_held = 1'b1;
						end else begin
							if (fc1 < tlf_pkg::FILL_MAX) begin
								wb.en   = 1'b1;
								wb.addr = fc1;
								fc2     = fc1 + IW'(1);
							end
							if (fc2 >= tlf_pkg::FILL_MAX) begin
								n_recv = 1'b0;
								n_held = 1'b1;
							end
						end
					end
					n_fill = fc2;
				end
			end
			tlf_pkg::ACT_RELEASE: begin
				n_held = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st_next.frame_ready  = n_held;
		st_next.frame_length = n_fill;
		st_next.hit          = (item.action == tlf_pkg::ACT_READ) && (item.read_index < fill_q);
		st_next.bank         = item.read_index[0];
		st_next.byte_dropped = dropped;
	end

	// even and odd banks of the frame store
	for (genvar k = 0; k < 2; k++) begin : g_bank
		logic                       we;
		logic [tlf_pkg::BANK_AW-1:0] waddr;
		logic [7:0]                 wdata;

		always_comb begin
			we    = 1'b0;
			waddr = wb.addr[IW-1:1];
			wdata = wb.data;
			if (wa.en && wa.addr[0] == 1'(k)) begin
				we    = accept;
				waddr = wa.addr[IW-1:1];
				wdata = wa.data;
			end else if (wb.en && wb.addr[0] == 1'(k)) begin
				we    = accept;
			end
		end

		tlf_ram #(
			.WIDTH (8),
			.DEPTH (tlf_pkg::BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (accept && item.action == tlf_pkg::ACT_READ),
			.raddr (item.read_index[IW-1:1]),
			.rdata (rdata[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q <= 1'b0;
			esc_q  <= 1'b0;
			held_q <= 1'b0;
			fill_q <= '0;
		end else if (accept) begin
			recv_q <= n_recv;
			esc_q  <= n_esc;
			held_q <= n_held;
			fill_q <= n_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1 <= st_next;
		end
		if (advance) begin
			out_q      <= st_s1;
			out_char_q <= st_s1.hit ? rdata[st_s1.bank] : 8'd0;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_ready  = out_q.frame_ready;
	assign result.frame_length = out_q.frame_length;
	assign result.read_char    = out_char_q;
	assign result.byte_dropped = out_q.byte_dropped;

endmodule
